### rtl/bbbr_pkg.sv
// Package: shared types and constants of the byte buffer bit reader.
`timescale 1ns / 1ps
package bbbr_pkg;
	localparam int BufDepth = 4096;
	localparam int AddrW    = $clog2(BufDepth);
	localparam int LenW     = $clog2(BufDepth + 1);

	typedef enum logic [1:0] {
		OP_RESTART = 2'd0,
		OP_APPEND  = 2'd1,
		OP_READ_LE = 2'd2,
		OP_READ_BE = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_WIDE  = 2'd1,
		ST_ENDED = 2'd2
	} status_t;

	localparam logic [63:0] WideValue = 64'h0000_0000_FFFF_FFFF;
	localparam logic [6:0]  MaxWidth  = 7'd64;

	// request queued between front and back
	typedef struct packed {
		opcode_t    op;
		logic [7:0] data;
		logic [6:0] width;
	} req_t;

	typedef enum logic [1:0] {
		EX_IDLE,
		EX_FETCH,
		EX_CHUNK,
		EX_DONE
	} ex_state_t;
endpackage

### rtl/bbbr_front.sv
// Front end: request intake and a two-entry queue toward the back end.
`timescale 1ns / 1ps
module bbbr_front import bbbr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  req_t       in_req,
	output logic       q_valid,
	input  logic       q_ready,
	output req_t       q_req
);
	req_t       mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_req    = mem_q[rd_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	// store incoming requests
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_req;
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

### rtl/bbbr_back.sv
// Back end: byte store, read position and chunk-by-chunk read sequencer.
`timescale 1ns / 1ps
module bbbr_back import bbbr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	output logic        q_ready,
	input  req_t        q_req,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] out_value,
	output status_t     out_status
);
	logic [7:0]      store [BufDepth];
	logic [7:0]      rd_data_q;
	logic [AddrW-1:0] rd_addr;
	logic            rd_en;

	logic [LenW-1:0] len_q, pos_q;
	logic [2:0]      bit_q;
	ex_state_t       st_q, st_d;
	logic            big_q, ended_q, have_cur_q;
	logic [6:0]      left_q;
	logic [7:0]      cur_q;
	logic [63:0]     val_q;

	logic            take;
	logic            is_read, res_set;
	logic [3:0]      n, endbit;
	logic [7:0]      lowv, hiv, chunk, mask_n;
	logic [2:0]      k;

	// LE placement: bits consumed so far equal total minus left, tracked by tot_q
	logic [6:0] tot_q;
	always_ff @(posedge clk) begin
		if (take) tot_q <= q_req.width;
	end

	function automatic logic [5:0] shamt(input logic [6:0] lf);
		logic [6:0] used;
		used  = tot_q - lf;
		shamt = {used[5:3], 3'd0};
	endfunction

	assign q_ready = (st_q == EX_IDLE) && (!out_valid || out_ready);
	assign take    = q_valid && q_ready;
	assign is_read = (q_req.op == OP_READ_LE) || (q_req.op == OP_READ_BE);

	// chunk width and bit arithmetic
	always_comb begin
		n      = (left_q >= 7'd8) ? 4'd8 : {1'b0, left_q[2:0]};
		endbit = {1'b0, bit_q} + n;
		k      = endbit[2:0];
		mask_n = 8'((9'd1 << n) - 9'd1);
		lowv   = cur_q >> bit_q;
		hiv    = rd_data_q & 8'((9'd1 << k) - 9'd1);
		if (big_q) chunk = 8'((lowv << k) + hiv);
		else       chunk = 8'(lowv + (hiv << (4'd8 - {1'b0, bit_q})));
	end

	// store write on append, byte read address
	always_ff @(posedge clk) begin
		if (take && q_req.op == OP_APPEND && len_q < LenW'(BufDepth))
			store[len_q[AddrW-1:0]] <= q_req.data;
		if (rd_en) rd_data_q <= store[rd_addr];
	end

	// next state, fetch control and result posting
	always_comb begin
		st_d    = st_q;
		rd_en   = 1'b0;
		rd_addr = pos_q[AddrW-1:0];
		res_set = 1'b0;
		unique case (st_q)
			EX_IDLE: begin
				if (take && is_read) begin
					if (q_req.width > MaxWidth) res_set = 1'b1;
					else st_d = EX_CHUNK;
				end
			end
			EX_FETCH: st_d = EX_CHUNK;
			EX_CHUNK: begin
				if (left_q == 7'd0 || ended_q) begin
					res_set = 1'b1;
					st_d    = EX_IDLE;
				end else if (pos_q >= len_q) begin
					st_d = EX_CHUNK;
				end else if (!have_cur_q || endbit > 4'd8) begin
					st_d = EX_FETCH;
				end
			end
			default: st_d = EX_IDLE;
		endcase
		// fetch current byte, or next one when a chunk crosses
		if (st_q == EX_CHUNK && left_q != 7'd0 && have_cur_q && endbit > 4'd8) begin
			rd_en   = 1'b1;
			rd_addr = AddrW'(pos_q + LenW'(1));
		end else if (st_q == EX_CHUNK && !have_cur_q) begin
			rd_en = 1'b1;
		end
	end

	// hold a posted result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (res_set) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= EX_IDLE;
			len_q      <= '0;
			pos_q      <= '0;
			bit_q      <= '0;
			have_cur_q <= 1'b0;
			big_q      <= 1'b0;
			ended_q    <= 1'b0;
			left_q     <= '0;
			cur_q      <= '0;
			val_q      <= '0;
			out_value  <= '0;
			out_status <= ST_OK;
		end else begin
			st_q <= st_d;
			unique case (st_q)
				EX_IDLE: if (take) begin
					unique case (q_req.op)
						OP_RESTART: begin
							len_q <= '0; pos_q <= '0; bit_q <= '0;
						end
						OP_APPEND: if (len_q < LenW'(BufDepth)) len_q <= len_q + LenW'(1);
						default: begin
							big_q      <= (q_req.op == OP_READ_BE);
							ended_q    <= 1'b0;
							val_q      <= '0;
							have_cur_q <= 1'b0;
							if (q_req.width > MaxWidth) begin
								out_value  <= WideValue;
								out_status <= ST_WIDE;
							end else begin
								left_q <= q_req.width;
							end
						end
					endcase
				end
				EX_CHUNK: begin
					if (left_q == 7'd0 || ended_q) begin
						out_value  <= val_q;
						out_status <= ended_q ? ST_ENDED : ST_OK;
					end else if (pos_q >= len_q) begin
						// ran off the end: park, rest yields zero
						ended_q <= 1'b1;
						pos_q   <= len_q;
						bit_q   <= '0;
						val_q   <= big_q ? (val_q << left_q) : val_q;
						left_q  <= '0;
					end else if (!have_cur_q) begin
					end else if (endbit > 4'd8) begin
					end else begin
						// chunk within current byte
						logic [7:0] c;
						c = (endbit == 4'd8) ? lowv : (lowv & mask_n);
						if (big_q) val_q <= (val_q << n) | {56'd0, c};
						else val_q <= val_q | ({56'd0, c} << shamt(left_q));
						left_q <= left_q - {3'd0, n};
						if (endbit == 4'd8) begin
							pos_q <= pos_q + LenW'(1); bit_q <= '0; have_cur_q <= 1'b0;
						end else bit_q <= endbit[2:0];
					end
				end
				EX_FETCH: begin
					if (!have_cur_q) begin
						cur_q <= rd_data_q; have_cur_q <= 1'b1;
					end else if (pos_q + LenW'(1) >= len_q) begin
						// crossing into a missing byte
						ended_q <= 1'b1;
						pos_q   <= len_q; bit_q <= '0;
						val_q   <= big_q
							? (((val_q << n) | {56'd0, lowv}) << (left_q - {3'd0, n}))
							: (val_q | ({56'd0, lowv} << shamt(left_q)));
						left_q  <= '0;
					end else begin
						val_q  <= big_q ? ((val_q << n) | {56'd0, chunk})
							: (val_q | ({56'd0, chunk} << shamt(left_q)));
						left_q <= left_q - {3'd0, n};
						pos_q  <= pos_q + LenW'(1);
						bit_q  <= k;
						cur_q  <= rd_data_q;
					end
				end
				default: ;
			endcase
		end
	end
endmodule

### rtl/byte_buffer_bit_reader.sv
// Top level: byte buffer bit reader with decoupled intake and execution.
//  channel | dir | fields (low bit up)
//  s_axis  | in  | tdata: opcode[1:0], data_byte[9:2], read_width[16:10]
//  m_axis  | out | tdata: read_value[63:0], read_status[65:64]
// Each request passes through the intake queue; restart and append then
// complete in the back end. A read proceeds chunk by chunk: fetch request,
// fetch and combine for a byte-aligned chunk; fetch request, then fetch and
// combine together for a chunk that crosses a byte edge; plus a start and a
// post step. The pace is set by the single read port of the byte store.
// arst_n clears position, length and queue; store contents are not cleared.
// A waiting result holds the back end; the queue takes two more, then stalls.
`timescale 1ns / 1ps
module byte_buffer_bit_reader import bbbr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // opcode, data_byte, read_width
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata   // read_value, read_status
);
	req_t    in_req, q_req;
	logic    q_valid, q_ready;
	logic [63:0] value;
	status_t status;

	assign in_req.op    = opcode_t'(s_axis_tdata[1:0]);
	assign in_req.data  = s_axis_tdata[9:2];
	assign in_req.width = s_axis_tdata[16:10];
	assign m_axis_tdata = {6'd0, status, value};

	bbbr_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_req,
		.q_valid, .q_ready, .q_req
	);

	bbbr_back u_back (
		.clk, .arst_n,
		.q_valid, .q_ready, .q_req,
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_value(value), .out_status(status)
	);
endmodule
